>>> design/bpmg_pkg.sv
// bpmg_pkg: shared types, constants and helper functions for the
// battery power mode governor; no dependencies

package bpmg_pkg;

	localparam int unsigned MV_W     = 16;
	localparam int unsigned RUN_W    = 4;
	localparam int unsigned FACTOR_W = 7;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [MV_W-1:0]  MIN_VALID_MV = 16'd1000;
	localparam logic [RUN_W-1:0] RUN_MAX      = 4'd15;

	localparam logic [MV_W-1:0]  ECO_MV_RST      = 16'd3700;
	localparam logic [MV_W-1:0]  SURVIVAL_MV_RST = 16'd3500;
	localparam logic [MV_W-1:0]  CRITICAL_MV_RST = 16'd3350;
	localparam logic [MV_W-1:0]  BOOTLOCK_MV_RST = 16'd3300;
	localparam logic [RUN_W-1:0] WORSE_RUN_RST    = 4'd2;
	localparam logic [RUN_W-1:0] BETTER_RUN_RST   = 4'd4;
	localparam logic [RUN_W-1:0] SHUTDOWN_RUN_RST = 4'd3;

	typedef enum logic [1:0] {
		MODE_NORMAL   = 2'd0,
		MODE_ECO      = 2'd1,
		MODE_SURVIVAL = 2'd2,
		MODE_CRITICAL = 2'd3
	} power_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ECO_MV       = 3'd0,
		CFG_SURVIVAL_MV  = 3'd1,
		CFG_CRITICAL_MV  = 3'd2,
		CFG_BOOTLOCK_MV  = 3'd3,
		CFG_WORSE_RUN    = 3'd4,
		CFG_BETTER_RUN   = 3'd5,
		CFG_SHUTDOWN_RUN = 3'd6
	} cfg_index_t;

	function automatic logic [FACTOR_W-1:0] wake_factor(input power_mode_t mode);
		logic [FACTOR_W-1:0] f;
		unique case (mode)
			MODE_NORMAL:   f = 7'd9;
			MODE_ECO:      f = 7'd19;
			MODE_SURVIVAL: f = 7'd49;
			MODE_CRITICAL: f = 7'd99;
			default:       f = 7'd9;
		endcase
		return f;
	endfunction

	function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] run);
		return (run == RUN_MAX) ? RUN_MAX : run + 4'd1;
	endfunction

endpackage

>>> design/bpmg_sample_if.sv
// bpmg_sample_if: sample channel (valid/ready plus one battery sample)
// depends on bpmg_pkg

interface bpmg_sample_if
	import bpmg_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [MV_W-1:0] battery_mv;
	logic            external_power;
	logic            start_req;

	modport source (output valid, output battery_mv, output external_power,
		output start_req, input ready);
	modport sink (input valid, input battery_mv, input external_power,
		input start_req, output ready);
endinterface

>>> design/bpmg_result_if.sv
// bpmg_result_if: result channel (valid/ready plus one governor result)
// depends on bpmg_pkg

interface bpmg_result_if
	import bpmg_pkg::*;
();
	logic                valid;
	logic                ready;
	power_mode_t         power_mode;
	logic [FACTOR_W-1:0] wake_interval_factor;
	logic                background_off;
	logic [MV_W-1:0]     reported_mv;
	logic                shutdown_request;

	modport source (output valid, output power_mode, output wake_interval_factor,
		output background_off, output reported_mv, output shutdown_request,
		input ready);
	modport sink (input valid, input power_mode, input wake_interval_factor,
		input background_off, input reported_mv, input shutdown_request,
		output ready);
endinterface

>>> design/bpmg_cfg_if.sv
// bpmg_cfg_if: register write channel (valid/ready, index, data)
// depends on bpmg_pkg

interface bpmg_cfg_if
	import bpmg_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MV_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/battery_power_mode_governor_core.sv
// battery_power_mode_governor_core: power mode governor top level
// depends on bpmg_pkg, bpmg_sample_if, bpmg_result_if, bpmg_cfg_if
//
// usage:
// - sample: one battery sample per transaction (reading, external power,
//   start flag); each accepted sample gives exactly one result transaction
// - result: mode, wake interval factor, background suppress, last valid
//   reading and shutdown request, in sample order
// - cfg: writes one of seven threshold/run registers; always ready, meant
//   to be used only while no sample is in flight
// - path: the input register is loaded when a sample is accepted, then the
//   classification and run counter update feed the result register, which
//   loads once the result register is empty or being drained
// - throughput: one sample per cycle unless the result stalls; the sample
//   input keeps taking transactions while the result register drains
// - result stall: the result register holds, the input register fills, and
//   sample.ready falls only when both are occupied
// - reset: mode normal, last reading and all run counters zero, registers
//   at their default thresholds, both stages empty

module battery_power_mode_governor_core
	import bpmg_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	bpmg_sample_if.sink   sample,
	bpmg_result_if.source result,
	bpmg_cfg_if.sink      cfg
);

	logic [MV_W-1:0]  eco_mv_q, survival_mv_q, critical_mv_q, bootlock_mv_q;
	logic [RUN_W-1:0] worse_need_q, better_need_q, shutdown_need_q;

	logic            valid_s1;
	logic [MV_W-1:0] mv_s1;
	logic            ext_s1;
	logic            start_s1;

	power_mode_t      mode_q;
	logic [MV_W-1:0]  last_mv_q;
	logic [RUN_W-1:0] worse_run_q, better_run_q, shutdown_run_q;

	logic            res_valid_q;
	power_mode_t     res_mode_q;
	logic [MV_W-1:0] res_mv_q;
	logic            res_shut_q;

	logic             advance;
	logic [MV_W-1:0]  mv_new;
	power_mode_t      target;
	power_mode_t      mode_nxt;
	logic [RUN_W-1:0] worse_nxt, better_nxt, shutdown_nxt;
	logic [RUN_W-1:0] worse_bump, better_bump, shutdown_bump;
	logic             shut_nxt;
	logic             low_cond;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eco_mv_q        <= ECO_MV_RST;
			survival_mv_q   <= SURVIVAL_MV_RST;
			critical_mv_q   <= CRITICAL_MV_RST;
			bootlock_mv_q   <= BOOTLOCK_MV_RST;
			worse_need_q    <= WORSE_RUN_RST;
			better_need_q   <= BETTER_RUN_RST;
			shutdown_need_q <= SHUTDOWN_RUN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ECO_MV:       eco_mv_q        <= cfg.data;
				CFG_SURVIVAL_MV:  survival_mv_q   <= cfg.data;
				CFG_CRITICAL_MV:  critical_mv_q   <= cfg.data;
				CFG_BOOTLOCK_MV:  bootlock_mv_q   <= cfg.data;
				CFG_WORSE_RUN:    worse_need_q    <= cfg.data[RUN_W-1:0];
				CFG_BETTER_RUN:   better_need_q   <= cfg.data[RUN_W-1:0];
				CFG_SHUTDOWN_RUN: shutdown_need_q <= cfg.data[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			mv_s1    <= sample.battery_mv;
			ext_s1   <= sample.external_power;
			start_s1 <= sample.start_req;
		end
	end

	// classification and run counters
	always_comb begin
		if (start_s1 || (mv_s1 > MIN_VALID_MV)) begin
			mv_new = mv_s1;
		end else begin
			mv_new = last_mv_q;
		end

		if (ext_s1) begin
			target = MODE_NORMAL;
		end else if (mv_new < MIN_VALID_MV) begin
			target = mode_q;
		end else if (mv_new <= critical_mv_q) begin
			target = MODE_CRITICAL;
		end else if (mv_new < survival_mv_q) begin
			target = MODE_SURVIVAL;
		end else if (mv_new < eco_mv_q) begin
			target = MODE_ECO;
		end else begin
			target = MODE_NORMAL;
		end
	end

	assign worse_bump    = run_bump(worse_run_q);
	assign better_bump   = run_bump(better_run_q);
	assign shutdown_bump = run_bump(shutdown_run_q);
	assign low_cond      = !ext_s1 && (mv_new > MIN_VALID_MV) && (mv_new <= bootlock_mv_q);

	always_comb begin
		mode_nxt     = mode_q;
		worse_nxt    = worse_run_q;
		better_nxt   = better_run_q;
		shutdown_nxt = shutdown_run_q;
		shut_nxt     = 1'b0;
		if (start_s1) begin
			mode_nxt = target;
		end else begin
			priority if (target > mode_q) begin
				better_nxt = '0;
				if (worse_bump >= worse_need_q) begin
					mode_nxt  = target;
					worse_nxt = '0;
				end else begin
					worse_nxt = worse_bump;
				end
			end else if (target < mode_q) begin
				worse_nxt = '0;
				if (better_bump >= better_need_q) begin
					mode_nxt   = power_mode_t'(mode_q - 2'd1);
					better_nxt = '0;
				end else begin
					better_nxt = better_bump;
				end
			end else begin
				worse_nxt  = '0;
				better_nxt = '0;
			end

			if (low_cond) begin
				shutdown_nxt = shutdown_bump;
				shut_nxt     = (shutdown_bump >= shutdown_need_q);
			end else begin
				shutdown_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_NORMAL;
			last_mv_q      <= '0;
			worse_run_q    <= '0;
			better_run_q   <= '0;
			shutdown_run_q <= '0;
		end else if (advance) begin
			mode_q         <= mode_nxt;
			last_mv_q      <= mv_new;
			worse_run_q    <= worse_nxt;
			better_run_q   <= better_nxt;
			shutdown_run_q <= shutdown_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_mode_q <= mode_nxt;
			res_mv_q   <= mv_new;
			res_shut_q <= shut_nxt;
		end
	end

	assign result.valid                = res_valid_q;
	assign result.power_mode           = res_mode_q;
	assign result.wake_interval_factor = wake_factor(res_mode_q);
	assign result.background_off       = (res_mode_q == MODE_SURVIVAL) ||
		(res_mode_q == MODE_CRITICAL);
	assign result.reported_mv          = res_mv_q;
	assign result.shutdown_request     = res_shut_q;

	// checks
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mode_q) && $stable(shutdown_run_q))
		else $error("governor state changed without a sample");

	a_runs_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!((worse_run_q != '0) && (better_run_q != '0)))
		else $error("worse and better runs both active");

	a_start_no_shutdown: assert property (@(posedge clk) disable iff (!arst_n)
		advance && start_s1 |=> !res_shut_q)
		else $error("shutdown raised on start sample");

	a_better_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !start_s1 |=> (mode_q >= $past(mode_q)) ||
			(mode_q == power_mode_t'($past(mode_q) - 2'd1)))
		else $error("mode improved by more than one level");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_mode_q == mode_q) && (res_mv_q == last_mv_q))
		else $error("result register out of step with governor state");

endmodule
